// ===== design/assert_macros.svh =====
// assertion macros shared by the breakpoint table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on aclk, off while reset is asserted
`define ASSERT_SYNC(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// next-cycle implication on aclk, off while reset is asserted
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg
// shared types and command codes of the breakpoint set table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

    localparam int COORD_W = 16;
    localparam int KEY_W   = 2 * COORD_W;
    localparam int TOTAL_W = 7;

    localparam logic [1:0] CMD_CHECK  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
    } in_word_t;

    typedef struct packed {
        logic               was_present;
        logic               changed;
        logic               table_full;
        logic [TOTAL_W-1:0] entry_total;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch word, compare all cells
        logic commit;   // apply update, load result register
    } ctl_cmd_t;

endpackage

`default_nettype wire

// ===== design/bst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bst_ctrl
// two-state sequencer: capture/compare, then commit into the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bst_ctrl
    import bst_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output ctl_cmd_t      cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_COMMIT = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign cmd.capture = s_valid && s_ready;
    assign cmd.commit  = (state_reg == ST_COMMIT) && out_free;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (cmd.commit) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_NEXT(a_capture_goes_commit, cmd.capture, state_reg == ST_COMMIT, "capture not followed by commit state")
    `ASSERT_NEXT(a_commit_shows_result, cmd.commit, m_valid_reg, "commit did not raise result valid")

endmodule

`default_nettype wire

// ===== design/bst_datapath.sv =====
// ----------------------------------------------------------------------------
// bst_datapath
// cell array with per-cell compare, packed insert and shift-down delete
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bst_datapath
    import bst_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire ctl_cmd_t cmd,
    input  wire in_word_t s_word,
    output out_word_t     m_word
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [KEY_W-1:0]       cell_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match_reg;
    logic [TABLE_DEPTH-1:0] shift_en;
    logic [KEY_W-1:0]       key_reg;
    logic [1:0]             op_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    out_word_t              result_reg;

    logic [KEY_W-1:0] key_in;
    logic             present;
    logic             is_full;
    logic             do_add;
    logic             do_remove;
    logic             refuse;

    assign key_in    = {s_word.y_coord, s_word.x_coord};
    assign present   = |match_reg;
    assign is_full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign do_add    = (op_reg == CMD_ADD) && !present && !is_full;
    assign refuse    = (op_reg == CMD_ADD) && !present && is_full;
    assign do_remove = (op_reg == CMD_REMOVE) && present;

    always_comb begin
        count_next = count_reg;
        if (do_add) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_remove) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg <= key_in;
            op_reg  <= s_word.command;
        end
        if (cmd.commit) begin
            result_reg.was_present <= present;
            result_reg.changed     <= do_add || do_remove;
            result_reg.table_full  <= refuse;
            result_reg.entry_total <= TOTAL_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        // only valid cells may match
        always_ff @(posedge aclk) begin
            if (cmd.capture) begin
                match_reg[i] <= (count_reg > CNT_W'(i)) && (cell_reg[i] == key_in);
            end
        end

        // cells at and above the hit move down one place
        assign shift_en[i] = |match_reg[i:0];

        if (i < TABLE_DEPTH - 1) begin : g_shift
            always_ff @(posedge aclk) begin
                if (cmd.commit) begin
                    if (do_add && (count_reg == CNT_W'(i))) begin
                        cell_reg[i] <= key_reg;
                    end else if (do_remove && shift_en[i]) begin
                        cell_reg[i] <= cell_reg[i+1];
                    end
                end
            end
        end else begin : g_last
            always_ff @(posedge aclk) begin
                if (cmd.commit && do_add && (count_reg == CNT_W'(i))) begin
                    cell_reg[i] <= key_reg;
                end
            end
        end
    end

    assign m_word = result_reg;

    `ASSERT_SYNC(a_count_in_range, count_reg <= CNT_W'(TABLE_DEPTH), "entry count above depth")
    `ASSERT_SYNC(a_single_hit, cmd.commit |-> $onehot0(match_reg), "pair matched more than one cell")
    `ASSERT_NEXT(a_count_held, !cmd.commit, $stable(count_reg), "entry count moved without commit")

endmodule

`default_nettype wire

// ===== design/breakpoint_set_table_top.sv =====
// result path: all cells compare at the accept edge, then the commit in the commit
//   state raises result valid
// a new word is accepted only after the last one has committed; the commit also
//   waits while the result register still holds a word the consumer has not taken
// two-step sequence: all cells compare in parallel in the accept cycle, the
//   insert or shift-down delete lands in the commit state
// reset (aresetn low, synchronous) empties the table and drops result valid
// ----------------------------------------------------------------------------
// breakpoint_set_table_top
// packed table of distinct (x, y) breakpoints with check, add and remove
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module breakpoint_set_table_top
    import bst_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,

    // command word in
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_word,

    // result word out
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_word_t     m_word
);

    // capture / commit strobes from the sequencer
    ctl_cmd_t cmd;

    // sequencer: accepts a word only when no item is in flight; the result
    // register lets the next word enter while a result still waits
    bst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // datapath: cells, per-cell comparators, entry count and result register;
    // the table stays packed so valid entries sit below the count
    bst_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_word  (s_word),
        .m_word  (m_word)
    );

endmodule

`default_nettype wire

// ===== test/breakpoint_set_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// breakpoint_set_table_top_tb
// self-checking bench: a directed table then random command streams are pushed
// through the breakpoint table and every result word is compared against its
// typed-in result or a behavioral copy of the packed table, with random back-pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module breakpoint_set_table_top_tb;
    import bst_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 10;
    localparam int DEPTH = 64;
    localparam int POOL_SIZE = 80;       // more keys than slots, so full-table adds happen
    localparam int PHASE_ITEMS = 165;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES = 300;
    localparam longint TIMEOUT_NS = 64'd5_000_000;

    // command value left unused by the block, acts as a check
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // keys are packed {y, x}
    localparam logic [KEY_W-1:0] KEY_ZERO   = 32'h0000_0000;
    localparam logic [KEY_W-1:0] KEY_ONES   = 32'hFFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_X_MAX  = 32'h0000_FFFF;
    localparam logic [KEY_W-1:0] KEY_Y_MAX  = 32'hFFFF_0000;
    localparam logic [KEY_W-1:0] KEY_MID    = 32'hABCD_1234;
    localparam logic [KEY_W-1:0] KEY_ALT    = 32'hAAAA_5555;
    localparam logic [KEY_W-1:0] KEY_ODD    = 32'h0007_0007;
    localparam logic [KEY_W-1:0] KEY_NEAR_X = 32'hFFFF_FFFE;
    localparam logic [KEY_W-1:0] KEY_NEAR_Y = 32'hFFFE_FFFF;

    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t res;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_word;

    // model of the packed table: index 0 is the oldest surviving entry
    logic [KEY_W-1:0] bp_table[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    out_word_t        pending_results[$];
    stim_row_t        directed_rows[$];

    // typed-in result that travels alongside the word on s_word
    bit        row_typed = 1'b0;
    out_word_t row_result = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int mismatches = 0;

    out_word_t predicted;
    out_word_t oldest;

    int phase_idle[4]  = '{0, 48, 0, 19};
    int phase_stall[4] = '{0, 0, 48, 19};

    breakpoint_set_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic in_word_t make_word(logic [1:0] cmd, logic [KEY_W-1:0] key);
        in_word_t w;
        w.command = cmd;
        w.x_coord = key[COORD_W-1:0];
        w.y_coord = key[KEY_W-1:COORD_W];
        return w;
    endfunction

    function automatic stim_row_t dir_row(logic [1:0] cmd, logic [KEY_W-1:0] key, bit typed,
                                          bit present, bit chg, bit full, int total);
        stim_row_t r;
        r.word = make_word(cmd, key);
        r.typed = typed;
        r.res.was_present = present;
        r.res.changed = chg;
        r.res.table_full = full;
        r.res.entry_total = TOTAL_W'(total);
        return r;
    endfunction

    // index of the key in the table, -1 when absent
    function automatic int find_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < bp_table.size(); i++) begin
            if (bp_table[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // apply one command word to the table copy and return its result word
    function automatic out_word_t apply_breakpoint_cmd(in_word_t w);
        logic [KEY_W-1:0] key;
        int hit;
        out_word_t r;
        key = {w.y_coord, w.x_coord};
        hit = find_key(key);
        r = '0;
        r.was_present = (hit >= 0);
        case (w.command)
            CMD_ADD: begin
                if (hit < 0) begin
                    if (bp_table.size() < DEPTH) begin
                        bp_table.push_back(key);
                        r.changed = 1'b1;
                    end else begin
                        r.table_full = 1'b1;
                    end
                end
            end
            CMD_REMOVE: begin
                // queue delete closes the gap, same as the shift-down
                if (hit >= 0) begin
                    bp_table.delete(hit);
                    r.changed = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.entry_total = TOTAL_W'(bp_table.size());
        return r;
    endfunction

    // pool holds at least 16 keys that are not in a full table
    function automatic logic [KEY_W-1:0] absent_pool_key();
        int j;
        j = $urandom_range(0, POOL_SIZE - 1);
        while (find_key(key_pool[j]) >= 0) begin
            j = (j + 1) % POOL_SIZE;
        end
        return key_pool[j];
    endfunction

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // offer one word from a falling edge, return at the falling edge after acceptance
    task automatic send_word(in_word_t w, bit typed, out_word_t res);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_word = w;
        row_typed = typed;
        row_result = res;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // accepted command words feed the predictor, result words are checked in order
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted = apply_breakpoint_cmd(s_word);
                pending_results.push_back(row_typed ? row_result : predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result word with none expected, actual %h", $time, m_word);
                    mismatches++;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("was_present", oldest.was_present, m_word.was_present);
                    check_field("changed", oldest.changed, m_word.changed);
                    check_field("table_full", oldest.table_full, m_word.table_full);
                    check_field("entry_total", oldest.entry_total, m_word.entry_total);
                end
            end
        end
    end

    // result side: random stalls, plus a long hold-off when asked for
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // hard stop in case the handshake locks up
    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial begin
        in_word_t w;
        logic [KEY_W-1:0] k;
        logic [1:0] cmd;
        int r;
        int choice;
        int seg;
        int sent;
        bit dup;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word = '0;

        // distinct random keys, with the all-zero and all-one pairs among them
        key_pool[0] = KEY_ZERO;
        key_pool[1] = KEY_ONES;
        for (int i = 2; i < POOL_SIZE; i++) begin
            do begin
                k = $urandom;
                dup = 1'b0;
                for (int j = 0; j < i; j++) begin
                    if (key_pool[j] == k) begin
                        dup = 1'b1;
                    end
                end
            end while (dup);
            key_pool[i] = k;
        end

        // directed table: empty-table check and remove, duplicate add, unused
        // command, delete from the middle, front and back with shift-down,
        // single-bit near misses; the full-table refusal comes with the fills
        directed_rows.push_back(dir_row(CMD_CHECK,  KEY_ZERO,   1, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CMD_REMOVE, KEY_ZERO,   1, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CMD_ADD,    KEY_ZERO,   1, 0, 1, 0, 1));
        directed_rows.push_back(dir_row(CMD_ADD,    KEY_ZERO,   1, 1, 0, 0, 1));
        directed_rows.push_back(dir_row(CMD_CHECK,  KEY_ZERO,   1, 1, 0, 0, 1));
        directed_rows.push_back(dir_row(CMD_ADD,    KEY_ONES,   1, 0, 1, 0, 2));
        directed_rows.push_back(dir_row(CMD_ADD,    KEY_X_MAX,  1, 0, 1, 0, 3));
        directed_rows.push_back(dir_row(CMD_ADD,    KEY_Y_MAX,  1, 0, 1, 0, 4));
        directed_rows.push_back(dir_row(CMD_ADD,    KEY_MID,    1, 0, 1, 0, 5));
        directed_rows.push_back(dir_row(CMD_ADD,    KEY_ALT,    1, 0, 1, 0, 6));
        directed_rows.push_back(dir_row(CMD_SPARE,  KEY_ONES,   1, 1, 0, 0, 6));
        directed_rows.push_back(dir_row(CMD_SPARE,  KEY_ODD,    1, 0, 0, 0, 6));
        directed_rows.push_back(dir_row(CMD_REMOVE, KEY_X_MAX,  1, 1, 1, 0, 5));
        directed_rows.push_back(dir_row(CMD_CHECK,  KEY_X_MAX,  1, 0, 0, 0, 5));
        directed_rows.push_back(dir_row(CMD_CHECK,  KEY_Y_MAX,  1, 1, 0, 0, 5));
        directed_rows.push_back(dir_row(CMD_REMOVE, KEY_ZERO,   1, 1, 1, 0, 4));
        directed_rows.push_back(dir_row(CMD_REMOVE, KEY_ALT,    1, 1, 1, 0, 3));
        directed_rows.push_back(dir_row(CMD_REMOVE, KEY_ALT,    1, 0, 0, 0, 3));
        directed_rows.push_back(dir_row(CMD_CHECK,  KEY_NEAR_X, 0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CMD_ADD,    KEY_NEAR_X, 0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CMD_CHECK,  KEY_NEAR_Y, 0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CMD_REMOVE, KEY_ONES,   0, 0, 0, 0, 0));
        directed_rows.push_back(dir_row(CMD_CHECK,  KEY_NEAR_X, 0, 0, 0, 0, 0));

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res);
        end

        // random part, one idling pattern per phase; every phase opens with a fill
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = phase_idle[phase];
            stall_pct = phase_stall[phase];
            sent = 0;
            seg = 0;
            while (sent < PHASE_ITEMS) begin
                choice = (seg == 0) ? 0 : $urandom_range(0, 9);
                // long receiver hold-off while the sender keeps pushing
                if (phase == 0 && seg == 1) begin
                    hold_request = HOLD_CYCLES;
                end
                seg++;
                if (choice < 2) begin
                    // fill to the top with the odd check mixed in
                    while (bp_table.size() < DEPTH) begin
                        if ($urandom_range(0, 7) == 0) begin
                            w = make_word(CMD_CHECK, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
                        end else begin
                            w = make_word(CMD_ADD, absent_pool_key());
                        end
                        send_word(w, 1'b0, '0);
                        sent++;
                    end
                    // full: absent pairs are refused, a present pair is a plain no-op
                    repeat (3) begin
                        send_word(make_word(CMD_ADD, absent_pool_key()), 1'b0, '0);
                        sent++;
                    end
                    k = bp_table[$urandom_range(0, DEPTH - 1)];
                    send_word(make_word(CMD_ADD, k), 1'b0, '0);
                    sent++;
                end else if (choice < 4) begin
                    // drain burst, mostly hits
                    repeat ($urandom_range(5, 40)) begin
                        if (bp_table.size() > 0) begin
                            k = bp_table[$urandom_range(0, bp_table.size() - 1)];
                        end else begin
                            k = $urandom;
                        end
                        send_word(make_word(CMD_REMOVE, k), 1'b0, '0);
                        sent++;
                    end
                end else begin
                    // mixed traffic on pool keys, live entries and raw random pairs
                    repeat (20) begin
                        r = $urandom_range(0, 99);
                        if (r < 30) begin
                            cmd = CMD_CHECK;
                        end else if (r < 65) begin
                            cmd = CMD_ADD;
                        end else if (r < 95) begin
                            cmd = CMD_REMOVE;
                        end else begin
                            cmd = CMD_SPARE;
                        end
                        r = $urandom_range(0, 99);
                        if (r < 15) begin
                            k = $urandom;
                        end else if (r < 55 && bp_table.size() > 0) begin
                            k = bp_table[$urandom_range(0, bp_table.size() - 1)];
                        end else begin
                            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                        end
                        send_word(make_word(cmd, k), 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        s_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        // catch any stray result word after the last one
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
